FILE: sv/note_onset_offset_segmenter_unit_defines.svh
// Assertion macros shared by the segmenter RTL.
// Each one expects clk and rst_n in scope.
`ifndef NOTE_ONSET_OFFSET_SEGMENTER_UNIT_DEFINES_SVH
`define NOTE_ONSET_OFFSET_SEGMENTER_UNIT_DEFINES_SVH

// Same-cycle implication
`define NOS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NOS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nos_pkg.sv
package nos_pkg;

  // Widths
  localparam int INDEX_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int MAG_BITS    = SAMPLE_BITS + 1;
  localparam int LEVEL_BITS  = 16;
  localparam int RUN_BITS    = 16;
  localparam int OUT_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ONSET   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SILENCE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD    = 2'd2;

  // Reset values: 0.02 and 0.005 of full scale, and 441 samples
  localparam logic [LEVEL_BITS-1:0] ONSET_RESET   = 16'd655;
  localparam logic [LEVEL_BITS-1:0] SILENCE_RESET = 16'd164;
  localparam logic [RUN_BITS-1:0]   HOLD_RESET    = 16'd441;

  localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] onset_level;
    logic [LEVEL_BITS-1:0] silence_level;
    logic [RUN_BITS-1:0]   hold_length;
  } cfg_t;

  typedef struct packed {
    logic                push;
    logic [OUT_BITS-1:0] start_index;
    logic [OUT_BITS-1:0] end_index;
  } note_t;

endpackage

FILE: sv/nos_input_stage.sv
module nos_input_stage
  import nos_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          consume,
  output logic                          item_valid,
  output logic [MAG_BITS-1:0]           item_mag
);

  logic                valid_r, valid_nxt;
  logic [MAG_BITS-1:0] mag_r, mag_nxt;
  logic                take;

  // Hold while the stored item cannot move on
  assign in_stall = valid_r && !consume;
  assign take     = in_valid && !in_stall;

  // Magnitude 0..32768, computed on the way in
  always_comb begin
    if (in_sample[SAMPLE_BITS-1]) begin
      mag_nxt = (MAG_BITS'(1) << SAMPLE_BITS) - {1'b0, in_sample};
    end else begin
      mag_nxt = {1'b0, in_sample};
    end
  end

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mag_r <= mag_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item_mag   = mag_r;

endmodule

FILE: sv/nos_gate_core.sv
`include "note_onset_offset_segmenter_unit_defines.svh"

module nos_gate_core
  import nos_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                item_valid,
  input  logic [MAG_BITS-1:0] item_mag,
  input  logic                out_free,
  output logic                consume,
  output note_t               note
);

  logic [INDEX_BITS-1:0] sample_index_r, sample_index_nxt;
  logic                  note_open_r, note_open_nxt;
  logic [INDEX_BITS-1:0] note_begin_r, note_begin_nxt;
  logic [RUN_BITS-1:0]   silent_run_r, silent_run_nxt;

  logic                  loud;
  logic                  quiet;
  logic [RUN_BITS-1:0]   run_inc;
  logic                  emit;
  logic [INDEX_BITS-1:0] end_full;

  // Classify the sample against both levels
  assign loud    = item_mag > {1'b0, cfg.onset_level};
  assign quiet   = !loud && note_open_r && (item_mag < {1'b0, cfg.silence_level});
  assign run_inc = (silent_run_r != RUN_MAX) ? silent_run_r + 1'b1 : silent_run_r;
  assign emit    = quiet && (run_inc >= cfg.hold_length);

  // A non-emitting item never waits on the output side
  assign consume = item_valid && (!emit || out_free);

  assign end_full         = sample_index_r - INDEX_BITS'(run_inc);
  assign note.push        = consume && emit;
  assign note.start_index = OUT_BITS'(note_begin_r);
  assign note.end_index   = OUT_BITS'(end_full);

  // Next state
  always_comb begin
    sample_index_nxt = sample_index_r + 1'b1;
    note_open_nxt    = note_open_r;
    note_begin_nxt   = note_begin_r;
    silent_run_nxt   = silent_run_r;
    if (loud) begin
      if (!note_open_r) begin
        note_begin_nxt = sample_index_r;
      end
      note_open_nxt  = 1'b1;
      silent_run_nxt = '0;
    end else if (quiet) begin
      if (emit) begin
        note_open_nxt  = 1'b0;
        silent_run_nxt = '0;
      end else begin
        silent_run_nxt = run_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_index_r <= '0;
      note_open_r    <= 1'b0;
      note_begin_r   <= '0;
      silent_run_r   <= '0;
    end else if (consume) begin
      sample_index_r <= sample_index_nxt;
      note_open_r    <= note_open_nxt;
      note_begin_r   <= note_begin_nxt;
      silent_run_r   <= silent_run_nxt;
    end
  end

  `NOS_ASSERT_NOW(a_emit_needs_open, note.push, note_open_r, "note closed without being open")
  `NOS_ASSERT_NOW(a_run_only_open, silent_run_r != '0, note_open_r, "silence counted with no note")
  `NOS_ASSERT_NEXT(a_close_clears, note.push, !note_open_r && silent_run_r == '0, "close did not clear")
  `NOS_ASSERT_NEXT(a_index_step, consume, sample_index_r == INDEX_BITS'($past(sample_index_r) + 1'b1), "index did not advance")

endmodule

FILE: sv/nos_out_reg.sv
module nos_out_reg
  import nos_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  note_t               note,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] out_start_index,
  output logic [OUT_BITS-1:0] out_end_index
);

  logic                valid_r, valid_nxt;
  logic [OUT_BITS-1:0] start_r;
  logic [OUT_BITS-1:0] end_r;

  // Empty, or being drained this cycle
  assign out_free = !valid_r || !out_stall;

  always_comb begin
    if (note.push) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (note.push) begin
      start_r <= note.start_index;
      end_r   <= note.end_index;
    end
  end

  assign out_valid       = valid_r;
  assign out_start_index = start_r;
  assign out_end_index   = end_r;

endmodule

FILE: sv/note_onset_offset_segmenter_unit.sv
// Channel  Direction  Handshake               Payload
// in_      input      in_valid / in_stall     in_sample (16b signed)
// out_     output     out_valid / out_stall   out_start_index, out_end_index (32b)
// cfg_     input      cfg_valid / cfg_ready   cfg_index (2b), cfg_data (16b)
//
// One sample per cycle while in_stall is low; out_valid rises once the closing note is registered.
// A sample passes through the input register, then the gate logic, then the result register.
// Synchronous active-low reset clears onset, silence and hold to 655 / 164 / 441 and all note state.
// A waiting result stalls only a sample that would close another note.
// cfg_ready is always high; index 3 is ignored.
module note_onset_offset_segmenter_unit
  import nos_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [OUT_BITS-1:0]           out_start_index,
  output logic [OUT_BITS-1:0]           out_end_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [LEVEL_BITS-1:0]         cfg_data
);

  cfg_t                cfg_r, cfg_nxt;
  logic                item_valid;
  logic [MAG_BITS-1:0] item_mag;
  logic                consume;
  logic                out_free;
  note_t               note;

  assign cfg_ready = 1'b1;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ONSET:   cfg_nxt.onset_level   = cfg_data;
        CFG_SILENCE: cfg_nxt.silence_level = cfg_data;
        CFG_HOLD:    cfg_nxt.hold_length   = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.onset_level   <= ONSET_RESET;
      cfg_r.silence_level <= SILENCE_RESET;
      cfg_r.hold_length   <= HOLD_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nos_input_stage u_input (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .consume    (consume),
    .item_valid (item_valid),
    .item_mag   (item_mag)
  );

  nos_gate_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item_mag   (item_mag),
    .out_free   (out_free),
    .consume    (consume),
    .note       (note)
  );

  nos_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .note            (note),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_start_index (out_start_index),
    .out_end_index   (out_end_index)
  );

endmodule
